// ===== rtl/shtk_pkg.sv =====
// ----------------------------------------------------------------------------
// shtk_pkg
// Shared constants and types for the shallow top-k percentile block.
// ----------------------------------------------------------------------------
package shtk_pkg;

    // Number of retained depths
    localparam int CAPACITY  = 64;

    // Field widths
    localparam int DEPTH_W   = 25;
    localparam int PCT_W     = 17;
    localparam int COUNT_W   = 32;
    localparam int ENTRIES_W = 7;
    localparam int FRAC_BITS = 16;

    // Derived widths
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int PROD_W    = PCT_W + COUNT_W;
    localparam int RANK_W    = PROD_W + 1 - FRAC_BITS;

    // Reset value of the percentile register (one half)
    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(32768);

    typedef logic signed [DEPTH_W-1:0] depth_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [FILL_W-1:0]         fill_t;

endpackage

// ===== rtl/shallow_top_k_percentile.sv =====
// ----------------------------------------------------------------------------
// shallow_top_k_percentile
// Keeps the CAPACITY shallowest depth samples in a sorted memory and reports
// the depth at a programmable percentile rank after every sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample_depth_mm with in_valid / in_stall. A request is
//   taken when in_valid is high and in_stall is low.
//   Output channel: decision_depth_mm, depth_valid, samples_seen and
//   entries_held with out_valid / out_stall; one result per sample.
//   cfg_wr_en writes percentile_fraction (16 fraction bits, 65536 = one);
//   write it only while the block is idle.
// Sequence:
//   After acceptance a sample runs the insertion walk (one stored entry per
//   cycle through the single read and write port), then rank multiply, clamp
//   and lookup read before its result is presented.
//   One sample at a time: the next request is taken in the cycle after the
//   result loads.
// Reset:
//   Clears the fill level, the sample counter and the output valid and sets
//   the percentile to one half. Memory entries at or above the fill level
//   are never read, so the memory is not cleared.
// Stall:
//   A finished result waits in the output register while out_stall is high;
//   the next sample may already be in work and holds until the register frees.
// ----------------------------------------------------------------------------
module shallow_top_k_percentile
    import shtk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [PCT_W-1:0]     percentile_fraction,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DEPTH_W-1:0]   sample_depth_mm,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DEPTH_W-1:0]   decision_depth_mm,
    output logic                 depth_valid,
    output logic [COUNT_W-1:0]   samples_seen,
    output logic [ENTRIES_W-1:0] entries_held
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_RANK  = 3'd4;
    localparam logic [2:0] ST_CLAMP = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;

    localparam addr_t LAST_ADDR = addr_t'(CAPACITY - 1);
    localparam addr_t PREV_ADDR = addr_t'(CAPACITY - 2);
    localparam logic [PROD_W:0] ROUND_UP = (PROD_W+1)'((1 << FRAC_BITS) - 1);

    // Control registers
    logic [2:0]           state_reg, state_next;
    fill_t                fill_reg, fill_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [PCT_W-1:0]     pct_reg;
    logic                 out_valid_reg, out_valid_next;

    // Datapath registers
    addr_t                idx_reg, idx_next;
    depth_t               sample_reg, sample_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    depth_t               decision_reg;
    logic                 dvalid_reg;
    logic [COUNT_W-1:0]   seen_reg;
    logic [ENTRIES_W-1:0] held_reg;

    // Memory ports
    depth_t               mem [CAPACITY];
    depth_t               rd_data_reg;
    logic                 rd_en, wr_en;
    addr_t                rd_addr, wr_addr;
    depth_t               wr_data;

    // Rank arithmetic
    logic [PROD_W:0]      prod_round;
    logic [RANK_W-1:0]    rank_raw, rank_clamped, fill_ext;
    logic                 out_load;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_READ) && (!out_valid_reg || !out_stall);

    // Rank = ceil(pct * count / 2^16), clamped to 1..fill
    always_comb
    begin
        prod_round = {1'b0, prod_reg} + ROUND_UP;
        rank_raw   = prod_round[PROD_W:FRAC_BITS];
        fill_ext   = RANK_W'(fill_reg);
        if (rank_raw == '0)
        begin
            rank_clamped = RANK_W'(1);
        end
        else if (rank_raw > fill_ext)
        begin
            rank_clamped = fill_ext;
        end
        else
        begin
            rank_clamped = rank_raw;
        end
    end

    // Sequencer: insertion walk from the tail, then percentile lookup
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        sample_next = sample_reg;
        prod_next   = prod_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = sample_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = depth_t'(sample_depth_mm);
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (fill_reg < fill_t'(CAPACITY))
                    begin
                        fill_next = fill_reg + fill_t'(1);
                        idx_next  = addr_t'(fill_reg);
                        if (fill_reg == '0)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = addr_t'(fill_reg - fill_t'(1));
                            state_next = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        // full: look at the deepest entry first
                        rd_en      = 1'b1;
                        rd_addr    = LAST_ADDR;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (sample_reg > rd_data_reg)
                begin
                    idx_next = LAST_ADDR;
                    if (LAST_ADDR == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = PREV_ADDR;
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    state_next = ST_RANK;
                end
            end

            ST_SHIFT:
            begin
                wr_en = 1'b1;
                if (rd_data_reg >= sample_reg)
                begin
                    // stop after entries equal to the sample
                    state_next = ST_RANK;
                end
                else
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - addr_t'(1);
                    if (idx_reg == addr_t'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - addr_t'(2);
                    end
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                state_next = ST_RANK;
            end

            ST_RANK:
            begin
                prod_next  = PROD_W'(pct_reg) * PROD_W'(count_reg);
                state_next = ST_CLAMP;
            end

            ST_CLAMP:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_t'(rank_clamped - RANK_W'(1));
                state_next = ST_READ;
            end

            ST_READ:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            pct_reg       <= PCT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pct_reg <= percentile_fraction;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        if (out_load)
        begin
            decision_reg <= rd_data_reg;
            dvalid_reg   <= (fill_reg != '0);
            seen_reg     <= count_reg;
            held_reg     <= ENTRIES_W'(fill_reg);
        end
    end

    // Sorted store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid         = out_valid_reg;
    assign decision_depth_mm = decision_reg;
    assign depth_valid       = dvalid_reg;
    assign samples_seen      = seen_reg;
    assign entries_held      = held_reg;

endmodule

// ===== rtl/shtk_checker.sv =====
// ----------------------------------------------------------------------------
// shtk_checker
// Port-level checks for the shallow top-k percentile block.
// ----------------------------------------------------------------------------
module shtk_checker
    import shtk_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_wr_en,
    input logic [PCT_W-1:0]     percentile_fraction,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [DEPTH_W-1:0]   sample_depth_mm,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [DEPTH_W-1:0]   decision_depth_mm,
    input logic                 depth_valid,
    input logic [COUNT_W-1:0]   samples_seen,
    input logic [ENTRIES_W-1:0] entries_held
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(decision_depth_mm)
            && $stable(samples_seen) && $stable(entries_held))
        else $error("stalled result changed");

    // Every result follows a sample, so the store is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth_valid && (entries_held != '0))
        else $error("result reports an empty store");

    // Entries held never exceed the samples seen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> COUNT_W'(entries_held) <= samples_seen)
        else $error("more entries held than samples seen");

    // One sample at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind shallow_top_k_percentile shtk_checker u_shtk_checker (.*);
